>>> rtl/gtd_pkg.sv
package gtd_pkg;

    // Recurrence state width (q1, q2), signed.
    localparam int STATE_BITS = 32;
    // Config register widths.
    localparam int COEFF_W    = 16;
    localparam int LEN_W      = 12;
    localparam int POW_W      = 63;
    // Sample counter follows the block length register.
    localparam int COUNT_BITS = LEN_W;
    // Q2.14 coefficient.
    localparam int FRAC_BITS  = 14;

    localparam int PROD_W     = 2 * STATE_BITS;
    // Power accumulator: (q1^2 + q2^2) << 14 minus coeff*q1*q2, plus headroom.
    localparam int ACC_RAW_W  = 2 * STATE_BITS + 18;
    localparam int ACC_W      = (ACC_RAW_W > FRAC_BITS + POW_W + 2) ?
                                ACC_RAW_W : FRAC_BITS + POW_W + 2;

    // Config register indexes.
    localparam int CFG_IDX_W        = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd2;

    localparam logic [COEFF_W-1:0] COEFF_RST     = '0;
    localparam logic [LEN_W-1:0]   BLOCK_LEN_RST = 12'd400;
    localparam logic [POW_W-1:0]   THRESHOLD_RST = 63'd500000;

    // Power accumulator operations.
    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD,    // acc = (prod << 14) + rounding half
        ACC_ADD,     // acc += prod << 14
        ACC_SUB_HI,  // acc -= prod << 16
        ACC_SUB_LO,  // acc -= prod
        ACC_SAT      // power = clamp(acc >> 14)
    } t_acc_op;

endpackage

>>> rtl/gtd_mul.sv
module gtd_mul (
    input  logic                                   i_clk,
    input  logic signed [gtd_pkg::STATE_BITS-1:0]  i_a,
    input  logic signed [gtd_pkg::STATE_BITS-1:0]  i_b,
    output logic signed [gtd_pkg::PROD_W-1:0]      o_prod
);

    logic signed [gtd_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

>>> rtl/gtd_pwr.sv
module gtd_pwr (
    input  logic                                i_clk,
    input  gtd_pkg::t_acc_op                    i_op,
    input  logic signed [gtd_pkg::PROD_W-1:0]   i_prod,
    output logic [gtd_pkg::POW_W-1:0]           o_power
);

    localparam int AW = gtd_pkg::ACC_W;
    localparam int FB = gtd_pkg::FRAC_BITS;
    localparam int PW = gtd_pkg::POW_W;

    logic signed [AW-1:0] r_acc;
    logic signed [AW-1:0] n_acc;
    logic signed [AW-1:0] prod_ext;
    logic [PW-1:0]        r_power;
    logic [PW-1:0]        n_sat;

    assign prod_ext = AW'(i_prod);

    always_comb begin
        n_acc = r_acc;
        case (i_op)
            gtd_pkg::ACC_LOAD:   n_acc = (prod_ext <<< FB) + (AW'(1) <<< (FB - 1));
            gtd_pkg::ACC_ADD:    n_acc = r_acc + (prod_ext <<< FB);
            gtd_pkg::ACC_SUB_HI: n_acc = r_acc - (prod_ext <<< 16);
            gtd_pkg::ACC_SUB_LO: n_acc = r_acc - prod_ext;
            default:             n_acc = r_acc;
        endcase
    end

    // Negative reads as zero; anything past 63 bits clamps.
    always_comb begin
        if (r_acc[AW-1]) begin
            n_sat = '0;
        end else if (|r_acc[AW-2:FB+PW]) begin
            n_sat = {PW{1'b1}};
        end else begin
            n_sat = r_acc[FB+PW-1:FB];
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (i_op == gtd_pkg::ACC_SAT) begin
            r_power <= n_sat;
        end
    end

    assign o_power = r_power;

endmodule

>>> rtl/goertzel_tone_detector_core.sv
// Per item: a sample that does not close a block goes through multiply and update.
// A block-closing sample then makes five more passes through the one shared 32x32
// multiplier, then clamp and threshold compare, plus any wait on a held result.
// One item at a time; o_in_stall is high while an item is in work.
// Reset (i_rst_n low, synchronous) clears q1, q2, the sample count and the output
// valid, and loads coeff = 0, block_length = 400, power_threshold = 500000.
module goertzel_tone_detector_core #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // sample channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [SAMPLE_BITS-1:0]             i_sample,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [gtd_pkg::POW_W-1:0]          o_power,
    output logic                               o_tone_present,
    // config write port
    input  logic                               i_cfg_we,
    input  logic [gtd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [gtd_pkg::POW_W-1:0]          i_cfg_data
);

    localparam int SB   = gtd_pkg::STATE_BITS;
    localparam int CW   = gtd_pkg::COEFF_W;
    localparam int PW   = gtd_pkg::PROD_W;
    localparam int FB   = gtd_pkg::FRAC_BITS;
    localparam int CB   = gtd_pkg::COUNT_BITS;
    // coeff*q1 rounded half up and shifted down by 14 bits, minus q2, plus sample: two bits of growth
    localparam int RW   = PW - FB;
    localparam int SUMW = RW + 2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REC_MUL,   // coeff * q1
        S_REC_UPD,   // q0 = round(coeff*q1) - q2 + x, count the sample
        S_P_Q1,      // q1 * q1
        S_P_Q2,      // q2 * q2, acc = q1^2 << 14 + half
        S_P_CQ,      // coeff * q1, acc += q2^2 << 14
        S_P_MH,      // hi(coeff*q1) * q2, keep the low 16 bits
        S_P_ML,      // lo(coeff*q1) * q2, acc -= hi part << 16
        S_P_SUB,     // acc -= lo part
        S_P_SAT,     // clamp to 63 bits, clear block state
        S_P_OUT      // threshold compare into the output register
    } t_state;

    t_state r_state;

    // config
    logic signed [CW-1:0]            r_coeff;
    logic [gtd_pkg::LEN_W-1:0]       r_block_len;
    logic [gtd_pkg::POW_W-1:0]       r_thresh;

    // recurrence state
    logic signed [SB-1:0]            r_q1;
    logic signed [SB-1:0]            r_q2;
    logic [CB-1:0]                   r_cnt;
    logic signed [SAMPLE_BITS-1:0]   r_x;
    logic [15:0]                     r_ml;

    // output register
    logic                            r_out_valid;
    logic [gtd_pkg::POW_W-1:0]       r_out_power;
    logic                            r_out_tone;

    // shared multiplier
    logic signed [SB-1:0]            mul_a;
    logic signed [SB-1:0]            mul_b;
    logic signed [PW-1:0]            prod;
    gtd_pkg::t_acc_op                acc_op;
    logic [gtd_pkg::POW_W-1:0]       power;

    logic signed [SB-1:0]            coeff_ext;
    logic signed [PW-1:0]            prod_rnd;
    logic signed [SUMW-1:0]          n_sum;
    logic signed [SB-1:0]            n_q0;
    logic [CB:0]                     n_cnt_inc;
    logic                            n_block_end;
    logic                            out_free;
    logic                            in_accept;

    assign coeff_ext = SB'(r_coeff);
    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;

    // Operand select for the shared multiplier
    always_comb begin
        mul_a = coeff_ext;
        mul_b = r_q1;
        unique case (r_state)
            S_P_Q1: begin
                mul_a = r_q1;
                mul_b = r_q1;
            end
            S_P_Q2: begin
                mul_a = r_q2;
                mul_b = r_q2;
            end
            S_P_MH: begin
                // coeff*q1 fits SB+16 bits; top SB bits are the high partial
                mul_a = prod[SB+15:16];
                mul_b = r_q2;
            end
            S_P_ML: begin
                mul_a = SB'({1'b0, r_ml});
                mul_b = r_q2;
            end
            default: begin
                mul_a = coeff_ext;
                mul_b = r_q1;
            end
        endcase
    end

    always_comb begin
        acc_op = gtd_pkg::ACC_HOLD;
        unique case (r_state)
            S_P_Q2:  acc_op = gtd_pkg::ACC_LOAD;
            S_P_CQ:  acc_op = gtd_pkg::ACC_ADD;
            S_P_ML:  acc_op = gtd_pkg::ACC_SUB_HI;
            S_P_SUB: acc_op = gtd_pkg::ACC_SUB_LO;
            S_P_SAT: acc_op = gtd_pkg::ACC_SAT;
            default: acc_op = gtd_pkg::ACC_HOLD;
        endcase
    end

    gtd_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    gtd_pwr u_pwr (
        .i_clk   (i_clk),
        .i_op    (acc_op),
        .i_prod  (prod),
        .o_power (power)
    );

    // Recurrence update: round half up on the Q2.14 product, saturate to state width
    always_comb begin
        prod_rnd = prod + (PW'(1) <<< (FB - 1));
        n_sum    = SUMW'($signed(prod_rnd[PW-1:FB])) - SUMW'(r_q2) + SUMW'(r_x);
        if (n_sum[SUMW-1:SB-1] == '0 || n_sum[SUMW-1:SB-1] == '1) begin
            n_q0 = n_sum[SB-1:0];
        end else if (n_sum[SUMW-1]) begin
            n_q0 = {1'b1, {(SB-1){1'b0}}};
        end else begin
            n_q0 = {1'b0, {(SB-1){1'b1}}};
        end
        // length zero closes every sample, as length one does
        n_cnt_inc   = {1'b0, r_cnt} + (CB+1)'(1);
        n_block_end = (n_cnt_inc >= {1'b0, r_block_len});
    end

    // Config writes; unknown index is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeff     <= gtd_pkg::COEFF_RST;
            r_block_len <= gtd_pkg::BLOCK_LEN_RST;
            r_thresh    <= gtd_pkg::THRESHOLD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                gtd_pkg::CFG_COEFF:     r_coeff     <= i_cfg_data[CW-1:0];
                gtd_pkg::CFG_BLOCK_LEN: r_block_len <= i_cfg_data[gtd_pkg::LEN_W-1:0];
                gtd_pkg::CFG_THRESHOLD: r_thresh    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer, state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_q1        <= '0;
            r_q2        <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // S_P_OUT handles the take of a held result itself
            if (r_out_valid && !i_out_stall && r_state != S_P_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        // centre: subtract half scale = flip the top bit
                        r_x     <= {~i_sample[SAMPLE_BITS-1], i_sample[SAMPLE_BITS-2:0]};
                        r_state <= S_REC_MUL;
                    end
                end
                S_REC_MUL: r_state <= S_REC_UPD;
                S_REC_UPD: begin
                    r_q2 <= r_q1;
                    r_q1 <= n_q0;
                    if (n_block_end) begin
                        r_state <= S_P_Q1;
                    end else begin
                        r_cnt   <= n_cnt_inc[CB-1:0];
                        r_state <= S_IDLE;
                    end
                end
                S_P_Q1:  r_state <= S_P_Q2;
                S_P_Q2:  r_state <= S_P_CQ;
                S_P_CQ:  r_state <= S_P_MH;
                S_P_MH: begin
                    r_ml    <= prod[15:0];
                    r_state <= S_P_ML;
                end
                S_P_ML:  r_state <= S_P_SUB;
                S_P_SUB: r_state <= S_P_SAT;
                S_P_SAT: begin
                    r_q1    <= '0;
                    r_q2    <= '0;
                    r_cnt   <= '0;
                    r_state <= S_P_OUT;
                end
                S_P_OUT: begin
                    // hold until the previous result has been taken
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_power <= power;
                        r_out_tone  <= (power > r_thresh);
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_power        = r_out_power;
    assign o_tone_present = r_out_tone;

endmodule

>>> tb/sv/tb_goertzel_tone_detector_core.sv
module tb_goertzel_tone_detector_core;

    localparam int SAMPLE_W      = 12;
    localparam int CFG_IDX_W     = gtd_pkg::CFG_IDX_W;
    localparam int POW_W         = gtd_pkg::POW_W;
    localparam int COEFF_W       = gtd_pkg::COEFF_W;
    localparam int LEN_W         = gtd_pkg::LEN_W;
    localparam int FRAC_BITS     = gtd_pkg::FRAC_BITS;
    localparam int COUNT_BITS    = gtd_pkg::COUNT_BITS;
    // Nothing accepted for this many cycles means the block is hung.
    localparam int IDLE_LIMIT    = 2000;
    // Covers a block-closing item with margin.
    localparam int SETTLE_CYCLES = 20;
    localparam int RANDOM_ITEMS  = 905;
    localparam int NUM_DIRECTED  = 37;

    localparam logic [CFG_IDX_W-1:0] CFG_COEFF       = gtd_pkg::CFG_COEFF;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LEN   = gtd_pkg::CFG_BLOCK_LEN;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = gtd_pkg::CFG_THRESHOLD;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED    = 2'd3;
    localparam logic [POW_W-1:0]     POWER_MAX       = '1;
    localparam logic [COEFF_W-1:0]   COEFF_MINUS_TWO = 16'h8000;
    localparam logic [COEFF_W-1:0]   COEFF_NEAR_TWO  = 16'h7FFF;
    localparam longint               Q_MAX           = 64'sd2147483647;
    localparam longint               Q_MIN           = -64'sd2147483648;

    typedef struct packed {
        logic [POW_W-1:0] power;
        logic             tone;
    } t_block_result;

    typedef enum logic {
        ROW_CFG,
        ROW_SAMPLE
    } t_row_kind;

    // One directed step: a register write, or a sample with an optional
    // hand-computed result (typed = 1) instead of the predictor's.
    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [POW_W-1:0]      data;
        logic [SAMPLE_W-1:0]   sample;
        logic                  typed;
        logic [POW_W-1:0]      power;
        logic                  tone;
    } t_stim_row;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_in_valid     = 1'b0;
    logic                 o_in_stall;
    logic [SAMPLE_W-1:0]  i_sample       = '0;
    logic                 o_out_valid;
    logic                 i_out_stall    = 1'b0;
    logic [POW_W-1:0]     o_power;
    logic                 o_tone_present;
    logic                 i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index    = '0;
    logic [POW_W-1:0]     i_cfg_data     = '0;

    // Hand-computed result riding along with the sample being driven.
    logic                 typed_row      = 1'b0;
    logic [POW_W-1:0]     typed_power    = '0;
    logic                 typed_tone     = 1'b0;

    // Shadow of the block: registers, recurrence state, sample count.
    longint               mdl_coeff;
    logic [LEN_W-1:0]     mdl_len;
    logic [POW_W-1:0]     mdl_thresh;
    longint               q1;
    longint               q2;
    int                   blk_count;

    t_block_result        expected_blocks [$];
    int                   mismatches     = 0;
    int                   idle_cycles    = 0;
    int                   stall_left     = 0;
    logic                 out_taken      = 1'b0;
    bit                   wait_drawn     = 1'b0;
    bit                   no_idling      = 1'b0;

    t_stim_row directed_rows [NUM_DIRECTED] = '{
        // length 1, coeff 0: power is simply x^2 of the one centered sample
        '{ROW_CFG,    CFG_BLOCK_LEN, 63'd1,    12'h000, 1'b0, 63'd0,       1'b0},
        '{ROW_SAMPLE, CFG_COEFF,     63'd0,    12'h000, 1'b1, 63'd4194304, 1'b1},
        '{ROW_SAMPLE, CFG_COEFF,     63'd0,    12'hFFF, 1'b1, 63'd4190209, 1'b1},
        '{ROW_SAMPLE, CFG_COEFF,     63'd0,    12'h800, 1'b1, 63'd0,       1'b0},
        '{ROW_SAMPLE, CFG_COEFF,     63'd0,    12'h7FF, 1'b1, 63'd1,       1'b0},
        // power equal to threshold is not a tone
        '{ROW_CFG,    CFG_THRESHOLD, 63'd4194304, 12'h000, 1'b0, 63'd0,    1'b0},
        '{ROW_SAMPLE, CFG_COEFF,     63'd0,    12'h000, 1'b1, 63'd4194304, 1'b0},
        '{ROW_SAMPLE, CFG_COEFF,     63'd0,    12'hFFF, 1'b1, 63'd4190209, 1'b0},
        '{ROW_CFG,    CFG_THRESHOLD, 63'd0,    12'h000, 1'b0, 63'd0,       1'b0},
        '{ROW_SAMPLE, CFG_COEFF,     63'd0,    12'h7FF, 1'b1, 63'd1,       1'b1},
        '{ROW_SAMPLE, CFG_COEFF,     63'd0,    12'h800, 1'b1, 63'd0,       1'b0},
        // write to an unmapped index must change nothing
        '{ROW_CFG,    CFG_UNMAPPED,  POWER_MAX, 12'h000, 1'b0, 63'd0,      1'b0},
        '{ROW_SAMPLE, CFG_COEFF,     63'd0,    12'h000, 1'b1, 63'd4194304, 1'b1},
        // zero length behaves as length one
        '{ROW_CFG,    CFG_BLOCK_LEN, 63'd0,    12'h000, 1'b0, 63'd0,       1'b0},
        '{ROW_SAMPLE, CFG_COEFF,     63'd0,    12'hFFF, 1'b1, 63'd4190209, 1'b1},
        '{ROW_SAMPLE, CFG_COEFF,     63'd0,    12'h800, 1'b1, 63'd0,       1'b0},
        '{ROW_CFG,    CFG_THRESHOLD, POWER_MAX, 12'h000, 1'b0, 63'd0,      1'b0},
        '{ROW_SAMPLE, CFG_COEFF,     63'd0,    12'h000, 1'b1, 63'd4194304, 1'b0},
        // coeff -2, longest block, then length cut below the running count
        '{ROW_CFG,    CFG_COEFF,     63'h8000, 12'h000, 1'b0, 63'd0,       1'b0},
        '{ROW_CFG,    CFG_BLOCK_LEN, 63'd4095, 12'h000, 1'b0, 63'd0,       1'b0},
        '{ROW_SAMPLE, CFG_COEFF,     63'd0,    12'hFFF, 1'b0, 63'd0,       1'b0},
        '{ROW_SAMPLE, CFG_COEFF,     63'd0,    12'h000, 1'b0, 63'd0,       1'b0},
        '{ROW_SAMPLE, CFG_COEFF,     63'd0,    12'hFFF, 1'b0, 63'd0,       1'b0},
        '{ROW_SAMPLE, CFG_COEFF,     63'd0,    12'h000, 1'b0, 63'd0,       1'b0},
        '{ROW_SAMPLE, CFG_COEFF,     63'd0,    12'hFFF, 1'b0, 63'd0,       1'b0},
        '{ROW_SAMPLE, CFG_COEFF,     63'd0,    12'h000, 1'b0, 63'd0,       1'b0},
        '{ROW_SAMPLE, CFG_COEFF,     63'd0,    12'hFFF, 1'b0, 63'd0,       1'b0},
        '{ROW_SAMPLE, CFG_COEFF,     63'd0,    12'h000, 1'b0, 63'd0,       1'b0},
        '{ROW_CFG,    CFG_BLOCK_LEN, 63'd3,    12'h000, 1'b0, 63'd0,       1'b0},
        '{ROW_SAMPLE, CFG_COEFF,     63'd0,    12'hFFF, 1'b0, 63'd0,       1'b0},
        // coeff just under +2, back to reset threshold, short block
        '{ROW_CFG,    CFG_COEFF,     63'h7FFF, 12'h000, 1'b0, 63'd0,       1'b0},
        '{ROW_CFG,    CFG_THRESHOLD, 63'd500000, 12'h000, 1'b0, 63'd0,     1'b0},
        '{ROW_CFG,    CFG_BLOCK_LEN, 63'd4,    12'h000, 1'b0, 63'd0,       1'b0},
        '{ROW_SAMPLE, CFG_COEFF,     63'd0,    12'hFFF, 1'b0, 63'd0,       1'b0},
        '{ROW_SAMPLE, CFG_COEFF,     63'd0,    12'h000, 1'b0, 63'd0,       1'b0},
        '{ROW_SAMPLE, CFG_COEFF,     63'd0,    12'hFFF, 1'b0, 63'd0,       1'b0},
        '{ROW_SAMPLE, CFG_COEFF,     63'd0,    12'h800, 1'b0, 63'd0,       1'b0}
    };

    goertzel_tone_detector_core #(
        .SAMPLE_BITS (SAMPLE_W)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample       (i_sample),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_power        (o_power),
        .o_tone_present (o_tone_present),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // One Goertzel step on the shadow state. Returns 1 when the sample closes
    // a block, with the block power and tone flag in res.
    function automatic bit goertzel_step(input logic [SAMPLE_W-1:0] raw,
                                         output t_block_result res);
        longint              x;
        longint              r;
        longint              q0;
        logic signed [127:0] w1;
        logic signed [127:0] w2;
        logic signed [127:0] wc;
        logic signed [127:0] acc;
        res = '0;
        x = raw;
        x = x - 2048;
        // coeff*q1 in Q2.14, rounded half up (arithmetic shift floors)
        r = (mdl_coeff * q1 + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        q0 = r - q2 + x;
        if (q0 > Q_MAX) begin
            q0 = Q_MAX;
        end else if (q0 < Q_MIN) begin
            q0 = Q_MIN;
        end
        q2 = q1;
        q1 = q0;
        if (blk_count + 1 < int'(mdl_len)) begin
            blk_count = (blk_count + 1) & ((1 << COUNT_BITS) - 1);
            return 1'b0;
        end
        // power = ((q1^2 + q2^2) << 14 - coeff*q1*q2 + half) >> 14, clamped
        w1  = q1;
        w2  = q2;
        wc  = mdl_coeff;
        acc = ((w1 * w1 + w2 * w2) <<< FRAC_BITS) - wc * w1 * w2
              + (128'sd1 <<< (FRAC_BITS - 1));
        if (acc < 0) begin
            res.power = '0;
        end else begin
            acc = acc >>> FRAC_BITS;
            res.power = (acc > 128'sh7FFF_FFFF_FFFF_FFFF) ? POWER_MAX : acc[POW_W-1:0];
        end
        res.tone  = res.power > mdl_thresh;
        q1        = 0;
        q2        = 0;
        blk_count = 0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 50) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    // Monitor: tracks register writes, predicts on every accepted sample,
    // checks every accepted result, and runs the hang watchdog.
    always @(posedge i_clk) begin : monitor
        t_block_result exp_res;
        bit            produced;
        bit            in_acc;
        bit            out_acc;
        if (!i_rst_n) begin
            mdl_coeff  = $signed(gtd_pkg::COEFF_RST);
            mdl_len    = gtd_pkg::BLOCK_LEN_RST;
            mdl_thresh = gtd_pkg::THRESHOLD_RST;
            q1         = 0;
            q2         = 0;
            blk_count  = 0;
            out_taken <= 1'b0;
        end else begin
            in_acc  = i_in_valid && !o_in_stall;
            out_acc = o_out_valid && !i_out_stall;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_COEFF:     mdl_coeff  = $signed(i_cfg_data[COEFF_W-1:0]);
                    CFG_BLOCK_LEN: mdl_len    = i_cfg_data[LEN_W-1:0];
                    CFG_THRESHOLD: mdl_thresh = i_cfg_data;
                    default: ;
                endcase
            end
            if (in_acc) begin
                produced = goertzel_step(i_sample, exp_res);
                if (typed_row) begin
                    exp_res.power = typed_power;
                    exp_res.tone  = typed_tone;
                    expected_blocks.push_back(exp_res);
                end else if (produced) begin
                    expected_blocks.push_back(exp_res);
                end
            end
            if (out_acc) begin
                if (expected_blocks.size() == 0) begin
                    report_mismatch($sformatf("unexpected result power=%0d tone=%0b",
                                              o_power, o_tone_present));
                end else begin
                    exp_res = expected_blocks.pop_front();
                    if (o_power !== exp_res.power) begin
                        report_mismatch($sformatf("power %0d, expected %0d",
                                                  o_power, exp_res.power));
                    end
                    if (o_tone_present !== exp_res.tone) begin
                        report_mismatch($sformatf("tone_present %0b, expected %0b (power %0d)",
                                                  o_tone_present, exp_res.tone,
                                                  exp_res.power));
                    end
                end
            end
            out_taken <= out_acc;
            if (in_acc || out_acc || i_cfg_we) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Result side backpressure: a random stall is drawn for each result once it shows up, none when no_idling is set.
    always @(negedge i_clk) begin
        if (out_taken) begin
            wait_drawn = 1'b0;
        end
        if (o_out_valid === 1'b1 && !wait_drawn) begin
            stall_left = no_idling ? 0 : $urandom_range(0, 16);
            wait_drawn = 1'b1;
        end
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Drop valid, let every pending result drain and the last non-closing
    // item finish before registers are touched.
    task automatic pause_for_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        typed_row  <= 1'b0;
        while (expected_blocks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [POW_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Drive one sample after a random gap and return once it is accepted.
    // With no gap valid simply stays high into the next item.
    task automatic push_sample(input logic [SAMPLE_W-1:0] s, input logic typed,
                               input logic [POW_W-1:0] pw, input logic tone);
        int gap;
        gap = no_idling ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_sample    <= s;
        typed_row   <= typed;
        typed_power <= pw;
        typed_tone  <= tone;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
    endtask

    function automatic logic [POW_W-1:0] random_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[POW_W-1:0];
    endfunction

    // Mostly full-range samples, some rail values, some near midscale.
    function automatic logic [SAMPLE_W-1:0] random_sample();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 14) begin
            return SAMPLE_W'($urandom_range(0, 4095));
        end else if (pick < 17) begin
            return pick[0] ? 12'hFFF : 12'h000;
        end
        return SAMPLE_W'($urandom_range(2040, 2056));
    endfunction

    initial begin : stimulus
        logic [POW_W-1:0] word;
        int               rand_items;
        int               n;
        rand_items = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                if (i == 0 || directed_rows[i-1].kind == ROW_SAMPLE) begin
                    pause_for_idle();
                end
                write_reg(directed_rows[i].index, directed_rows[i].data);
            end else begin
                push_sample(directed_rows[i].sample, directed_rows[i].typed,
                            directed_rows[i].power, directed_rows[i].tone);
            end
        end

        // random phases: new register settings between bursts of samples;
        // blocks may straddle phases, so length changes land mid-block too
        while (rand_items < RANDOM_ITEMS) begin
            pause_for_idle();
            no_idling = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1) == 1) begin
                word = random_word();
                case ($urandom_range(0, 3))
                    0: word[COEFF_W-1:0] = COEFF_MINUS_TWO;
                    1: word[COEFF_W-1:0] = COEFF_NEAR_TWO;
                    2: word[COEFF_W-1:0] = '0;
                    default: ;
                endcase
                write_reg(CFG_COEFF, word);
            end
            if ($urandom_range(0, 3) != 0) begin
                word = random_word();
                n = $urandom_range(0, 19);
                if (n == 0) begin
                    word[LEN_W-1:0] = '0;
                end else if (n == 1) begin
                    word[LEN_W-1:0] = '1;
                end else if (n < 4) begin
                    word[LEN_W-1:0] = LEN_W'($urandom_range(13, 64));
                end else begin
                    word[LEN_W-1:0] = LEN_W'($urandom_range(1, 12));
                end
                write_reg(CFG_BLOCK_LEN, word);
            end
            if ($urandom_range(0, 1) == 1) begin
                case ($urandom_range(0, 5))
                    0:       word = '0;
                    1:       word = POWER_MAX;
                    default: word = random_word() >> $urandom_range(0, 62);
                endcase
                write_reg(CFG_THRESHOLD, word);
            end
            if ($urandom_range(0, 15) == 0) begin
                write_reg(CFG_UNMAPPED, random_word());
            end
            n = $urandom_range(1, 40);
            repeat (n) push_sample(random_sample(), 1'b0, '0, 1'b0);
            rand_items += n;
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_blocks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
